[design/median_of_sample_set_macros.svh]
// assertion macros for the median of sample set block
// expects clk and rst_n in the scope of each use
`ifndef MEDIAN_OF_SAMPLE_SET_MACROS_SVH
`define MEDIAN_OF_SAMPLE_SET_MACROS_SVH

// same-cycle implication, checked out of reset
`define MOS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median_of_sample_set: assertion failed");

// next-cycle implication, checked out of reset
`define MOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median_of_sample_set: assertion failed");

`endif

[design/mos_pkg.sv]
// shared types and constants for the median of sample set block
// no dependencies
package mos_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 6;

    typedef enum logic
    {
        CMD_PUSH   = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_FIN_A,
        S_FIN_B,
        S_FIN_OUT
    } state_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed
    {
        cmd_t    command;
        sample_t sample;
    } in_item_t;

    typedef struct packed
    {
        sample_t              median_value;
        status_t              status;
        logic [COUNT_W-1:0]   sample_count;
    } out_item_t;

endpackage

[design/median_of_sample_set.sv]
// median of sample set: top level with control sequencer and result register
// depends on mos_pkg, mos_ram and median_of_sample_set_macros.svh
//
// usage
// - item channel (item_valid / item_ready / item): a push adds a signed sample
//   to the set, a finish reports the median and empties the set
// - result channel (result_valid / result_ready / result): one transfer per
//   finish carrying median, status and number of kept samples
// - samples sit in ascending order in a single-port-write store; a push walks
//   down from the top entry, one entry per cycle, moving larger samples up
// - push: into an empty set the sample is written, into a full one dropped,
//   while idle; otherwise S_SHIFT, then S_PLACE if it is the smallest sample
// - finish: S_FIN_A reads the middle sample (odd count) or S_FIN_B averages the
//   middle two (even count), then S_FIN_OUT loads the result register; empty skips both
// - item_ready is high only while the sequencer is idle; pushes are taken
//   while an earlier result still waits on the result channel
// - a stalled result holds its register; a following finish waits for it
// - reset empties the set and clears the overflow flag; the store itself is
//   never cleared, only entries below the fill count are read
`include "median_of_sample_set_macros.svh"

module median_of_sample_set #(
    parameter int DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mos_pkg::in_item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output mos_pkg::out_item_t  result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mos_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      pos_reg, pos_next;
    mos_pkg::sample_t   x_reg, x_next;
    mos_pkg::sample_t   a_reg, a_next;
    mos_pkg::sample_t   med_reg, med_next;
    mos_pkg::out_item_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               we;
    logic [AW-1:0]      waddr;
    mos_pkg::sample_t   wdata;
    logic [AW-1:0]      raddr;
    mos_pkg::sample_t   rdata;

    logic               accept;
    logic               slot_free;
    logic signed [mos_pkg::SAMPLE_W:0] pair_sum;
    logic signed [mos_pkg::SAMPLE_W:0] pair_half;
    logic [CW+mos_pkg::COUNT_W-1:0]    count_wide;
    logic [CW-1:0]      pos_dec;
    logic [CW-1:0]      pos_dec2;
    logic [CW-1:0]      count_dec;
    logic [CW-1:0]      count_half;

    mos_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign item_ready   = (state_reg == mos_pkg::S_IDLE);
    assign accept       = item_valid && item_ready;
    assign slot_free    = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign pos_dec    = pos_reg - CW'(1);
    assign pos_dec2   = pos_reg - CW'(2);
    assign count_dec  = count_reg - CW'(1);
    assign count_half = count_reg >> 1;
    assign count_wide = {{mos_pkg::COUNT_W{1'b0}}, count_reg};

    // truncation toward zero: add one before the shift when the sum is negative
    assign pair_sum  = {a_reg[mos_pkg::SAMPLE_W-1], a_reg}
                     + {rdata[mos_pkg::SAMPLE_W-1], rdata};
    assign pair_half = (pair_sum + {{mos_pkg::SAMPLE_W{1'b0}}, pair_sum[mos_pkg::SAMPLE_W]})
                       >>> 1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        x_next         = x_reg;
        a_next         = a_reg;
        med_next       = med_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        we             = 1'b0;
        waddr          = pos_reg[AW-1:0];
        wdata          = x_reg;
        raddr          = pos_dec2[AW-1:0];

        unique case (state_reg)
            mos_pkg::S_IDLE:
            begin
                if (item.command == mos_pkg::CMD_PUSH)
                begin
                    raddr = count_dec[AW-1:0];
                end
                else
                begin
                    raddr = count_half[AW-1:0];
                end
                if (accept)
                begin
                    x_next = item.sample;
                    if (item.command == mos_pkg::CMD_PUSH)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata      = item.sample;
                            count_next = CW'(1);
                        end
                        else
                        begin
                            pos_next   = count_reg;
                            state_next = mos_pkg::S_SHIFT;
                        end
                    end
                    else
                    begin
                        med_next = '0;
                        pos_next = count_half;
                        if (count_reg == '0)
                        begin
                            state_next = mos_pkg::S_FIN_OUT;
                        end
                        else
                        begin
                            state_next = mos_pkg::S_FIN_A;
                        end
                    end
                end
            end

            mos_pkg::S_SHIFT:
            begin
                we    = 1'b1;
                waddr = pos_reg[AW-1:0];
                if (rdata > x_reg)
                begin
                    wdata    = rdata;
                    pos_next = pos_dec;
                    if (pos_reg == CW'(1))
                    begin
                        state_next = mos_pkg::S_PLACE;
                    end
                end
                else
                begin
                    wdata      = x_reg;
                    count_next = count_reg + CW'(1);
                    state_next = mos_pkg::S_IDLE;
                end
            end

            mos_pkg::S_PLACE:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = x_reg;
                count_next = count_reg + CW'(1);
                state_next = mos_pkg::S_IDLE;
            end

            mos_pkg::S_FIN_A:
            begin
                raddr = pos_dec[AW-1:0];
                if (count_reg[0])
                begin
                    med_next   = rdata;
                    state_next = mos_pkg::S_FIN_OUT;
                end
                else
                begin
                    a_next     = rdata;
                    state_next = mos_pkg::S_FIN_B;
                end
            end

            mos_pkg::S_FIN_B:
            begin
                med_next   = pair_half[mos_pkg::SAMPLE_W-1:0];
                state_next = mos_pkg::S_FIN_OUT;
            end

            mos_pkg::S_FIN_OUT:
            begin
                if (slot_free)
                begin
                    out_next.median_value = med_reg;
                    out_next.sample_count = count_wide[mos_pkg::COUNT_W-1:0];
                    if (count_reg == '0)
                    begin
                        out_next.status = mos_pkg::ST_EMPTY;
                    end
                    else if (ovf_reg)
                    begin
                        out_next.status = mos_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        out_next.status = mos_pkg::ST_OK;
                    end
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = mos_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mos_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mos_pkg::S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        x_reg   <= x_next;
        a_reg   <= a_next;
        med_reg <= med_next;
        out_reg <= out_next;
    end

    `MOS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `MOS_ASSERT_NEXT(a_drop_flags, accept && item.command == mos_pkg::CMD_PUSH
        && count_reg == CW'(DEPTH), ovf_reg && count_reg == CW'(DEPTH))
    `MOS_ASSERT_SAME(a_empty_result, result_valid && result.status == mos_pkg::ST_EMPTY,
        result.sample_count == '0 && result.median_value == '0)

endmodule

[design/mos_ram.sv]
// sorted sample store: one write port, one read port, registered read data
// depends on mos_pkg
module mos_ram #(
    parameter int DEPTH = 32
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  mos_pkg::sample_t             wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output mos_pkg::sample_t             rdata
);

    mos_pkg::sample_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[verif/median_of_sample_set_test.sv]
`timescale 1ns / 100ps
// self-checking bench for median_of_sample_set: predicts each finish result from a sorted copy
// of the pushed samples and compares every result transfer field by field; depends on mos_pkg
module median_of_sample_set_test;

    localparam int STORE_DEPTH = 32;
    localparam int ITEM_TARGET = 1300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;

    class running_median;
        mos_pkg::sample_t   held[STORE_DEPTH];
        int                 held_count;
        bit                 dropped;
        mos_pkg::out_item_t medians_due[$];
        int                 mismatch_count;

        function new();
            held_count = 0;
            dropped = 1'b0;
            mismatch_count = 0;
        endfunction

        task flag_mismatch(input string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatch_count++;
        endtask

        function void take_item(input mos_pkg::in_item_t x);
            int                 pos;
            int                 mid;
            int                 total;
            mos_pkg::out_item_t due;
            if (x.command == mos_pkg::CMD_PUSH)
            begin
                if (held_count < STORE_DEPTH)
                begin
                    pos = held_count;
                    while (pos > 0 && held[pos - 1] > x.sample)
                    begin
                        held[pos] = held[pos - 1];
                        pos--;
                    end
                    held[pos] = x.sample;
                    held_count++;
                end
                else
                begin
                    dropped = 1'b1;
                end
            end
            else
            begin
                due.sample_count = mos_pkg::COUNT_W'(held_count);
                if (held_count == 0)
                begin
                    due.median_value = '0;
                    due.status = mos_pkg::ST_EMPTY;
                end
                else
                begin
                    mid = held_count / 2;
                    if (held_count % 2 == 0)
                    begin
                        total = int'(held[mid]) + int'(held[mid - 1]);
                        due.median_value = mos_pkg::sample_t'(total / 2);
                    end
                    else
                    begin
                        due.median_value = held[mid];
                    end
                    due.status = dropped ? mos_pkg::ST_OVERFLOW : mos_pkg::ST_OK;
                end
                medians_due.push_back(due);
                held_count = 0;
                dropped = 1'b0;
            end
        endfunction

        task compare_result(input mos_pkg::out_item_t got);
            mos_pkg::out_item_t due;
            if (medians_due.size() == 0)
            begin
                flag_mismatch($sformatf("result transfer with no finish pending (median %0d)",
                                        got.median_value));
            end
            else
            begin
                due = medians_due.pop_front();
                if (got.median_value !== due.median_value)
                    flag_mismatch($sformatf("median_value %0d, expected %0d",
                                            got.median_value, due.median_value));
                if (got.status !== due.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, due.status));
                if (got.sample_count !== due.sample_count)
                    flag_mismatch($sformatf("sample_count %0d, expected %0d",
                                            got.sample_count, due.sample_count));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    mos_pkg::in_item_t  item;
    logic               result_valid;
    logic               result_ready;
    mos_pkg::out_item_t result;

    running_median tracker = new();
    int            items_sent;
    int            cycle_count = 0;
    int            stall_left;
    bit            calm;

    median_of_sample_set #(
        .DEPTH(STORE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // alternate between idle-free stretches and stretches with random gaps
    initial
    begin
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm <= ~calm;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: check each transfer, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
                tracker.compare_result(result);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                result_ready <= 1'b0;
            end
            else if (pick_gap() > 0)
            begin
                stall_left <= pick_gap();
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input mos_pkg::in_item_t x);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= x;
        do @(posedge clk); while (!item_ready);
        tracker.take_item(x);
        items_sent++;
    endtask

    task automatic push_sample(input int v);
        mos_pkg::in_item_t x;
        x.command = mos_pkg::CMD_PUSH;
        x.sample = mos_pkg::sample_t'(v);
        send_item(x);
    endtask

    task automatic finish_set();
        mos_pkg::in_item_t x;
        x.command = mos_pkg::CMD_FINISH;
        x.sample = mos_pkg::sample_t'($urandom);
        send_item(x);
    endtask

    task automatic hold_until_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (tracker.medians_due.size() != 0);
    endtask

    function automatic int random_sample(input int flavour);
        int pick;
        case (flavour)
            1: return int'($urandom_range(0, 8)) - 4;
            2:
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0) return -32768;
                if (pick == 1) return -32767;
                if (pick == 2) return 32766;
                return 32767;
            end
            default: return int'(mos_pkg::sample_t'($urandom));
        endcase
    endfunction

    task automatic random_set();
        int r;
        int n;
        int flavour;
        r = $urandom_range(0, 99);
        if (r < 5)
            n = 0;
        else if (r < 80)
            n = $urandom_range(1, 8);
        else if (r < 92)
            n = $urandom_range(9, 31);
        else
            n = $urandom_range(32, 40);
        flavour = $urandom_range(0, 3);
        for (int k = 0; k < n; k++)
            push_sample(random_sample(flavour));
        finish_set();
    endtask

    initial
    begin
        int set_index;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        items_sent = 0;
        set_index = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set
        finish_set();
        // extremes, even count halves toward zero
        push_sample(32767);
        push_sample(-32768);
        finish_set();
        push_sample(5);
        finish_set();
        push_sample(-3);
        push_sample(-4);
        finish_set();
        push_sample(32767);
        push_sample(32767);
        finish_set();
        push_sample(-32768);
        push_sample(-32768);
        push_sample(0);
        finish_set();
        push_sample(7);
        push_sample(4);
        finish_set();
        // duplicates in the middle
        push_sample(3);
        push_sample(1);
        push_sample(2);
        push_sample(2);
        finish_set();

        while (items_sent < ITEM_TARGET)
        begin
            random_set();
            set_index++;
            if (set_index % 50 == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.medians_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
